/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked checks on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CFIC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define CFIC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/cfic_pkg.sv */
// ----------------------------------------------------------------------------
// cfic_pkg
// Shared types, constants and byte functions of the frame integrity checker.
// ----------------------------------------------------------------------------
package cfic_pkg;

	localparam int CFG_INDEX_BITS = 2;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1,
		REG_CAPACITY     = 2'd2,
		REG_PATTERN_EN   = 2'd3
	} cfg_reg_t;

	localparam int WIDTH_RESET    = 324;
	localparam int HEIGHT_RESET   = 244;
	localparam int CAPACITY_RESET = 79056;

	localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
	localparam logic [31:0] CRC_PRESET = 32'hFFFF_FFFF;

	// Pattern verdict flags handed to the result stage
	typedef struct packed {
		logic ok;
		logic rotate_left;
	} pat_status_t;

	function automatic logic [7:0] rot_l(input logic [7:0] v);
		return {v[6:0], v[7]};
	endfunction

	function automatic logic [7:0] rot_r(input logic [7:0] v);
		return {v[0], v[7:1]};
	endfunction

	function automatic logic one_hot(input logic [7:0] v);
		return (v != 8'd0) && ((v & (v - 8'd1)) == 8'd0);
	endfunction

	// Reflected CRC-32, one byte
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

/* sv/cfic_regs.sv */
// ----------------------------------------------------------------------------
// cfic_regs
// Configuration registers and the registered payload size width*height.
// ----------------------------------------------------------------------------
module cfic_regs #(
	parameter int COORD_BITS = 12,
	parameter int COUNT_BITS = 24,
	parameter int DATA_BITS  = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [cfic_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [DATA_BITS-1:0]                cfg_data,
	output logic [COORD_BITS-1:0]               frame_width,
	output logic [COORD_BITS-1:0]               frame_height,
	output logic [COUNT_BITS-1:0]               capacity,
	output logic                                pattern_en,
	output logic [2*COORD_BITS-1:0]             payload
);

	localparam int PAY_BITS = 2 * COORD_BITS;
	localparam logic [COORD_BITS-1:0] W_RST = COORD_BITS'(cfic_pkg::WIDTH_RESET);
	localparam logic [COORD_BITS-1:0] H_RST = COORD_BITS'(cfic_pkg::HEIGHT_RESET);
	localparam logic [COUNT_BITS-1:0] C_RST = COUNT_BITS'(cfic_pkg::CAPACITY_RESET);
	localparam logic [PAY_BITS-1:0]   P_RST = PAY_BITS'(W_RST) * PAY_BITS'(H_RST);

	logic [COORD_BITS-1:0] width_q;
	logic [COORD_BITS-1:0] height_q;
	logic [COUNT_BITS-1:0] capacity_q;
	logic                  pattern_en_q;
	logic [PAY_BITS-1:0]   payload_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q      <= W_RST;
			height_q     <= H_RST;
			capacity_q   <= C_RST;
			pattern_en_q <= 1'b1;
		end else if (cfg_write) begin
			unique case (cfic_pkg::cfg_reg_t'(cfg_index))
				cfic_pkg::REG_FRAME_WIDTH:  width_q      <= cfg_data[COORD_BITS-1:0];
				cfic_pkg::REG_FRAME_HEIGHT: height_q     <= cfg_data[COORD_BITS-1:0];
				cfic_pkg::REG_CAPACITY:     capacity_q   <= cfg_data[COUNT_BITS-1:0];
				cfic_pkg::REG_PATTERN_EN:   pattern_en_q <= cfg_data[0];
			endcase
		end
	end

	// Registered product of the size registers; follows them in the next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			payload_q <= P_RST;
		end else begin
			payload_q <= PAY_BITS'(width_q) * PAY_BITS'(height_q);
		end
	end

	assign frame_width  = width_q;
	assign frame_height = height_q;
	assign capacity     = capacity_q;
	assign pattern_en   = pattern_en_q;
	assign payload      = payload_q;

endmodule

/* sv/cfic_pattern.sv */
// ----------------------------------------------------------------------------
// cfic_pattern
// Walking-one pattern tracker: position, direction and first mismatch.
// ----------------------------------------------------------------------------
module cfic_pattern #(
	parameter int COORD_BITS = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic                  stored,
	input  logic                  last,
	input  logic [7:0]            pix,
	input  logic [COORD_BITS-1:0] frame_width,
	input  logic [COORD_BITS-1:0] frame_height,
	input  logic                  pattern_en,
	output cfic_pkg::pat_status_t status,
	output logic [COORD_BITS-1:0] rec_col,
	output logic [COORD_BITS-1:0] rec_row,
	output logic [7:0]            rec_exp,
	output logic [7:0]            rec_act
);

	logic [COORD_BITS-1:0] col_q, row_q, col_n, row_n;
	logic [7:0]            first_q, first_n, expect_q, expect_n;
	logic                  dir_q, dir_n, failed_q, failed_n;
	logic [COORD_BITS-1:0] fcol_q, frow_q, fcol_n, frow_n;
	logic [7:0]            fexp_q, fact_q, fexp_n, fact_n;

	logic                  geom_ok, check_on, in_rows, at_origin, at_second;
	logic [COORD_BITS:0]   col_inc;
	logic [7:0]            cmp_exp;
	logic                  end_failed;
	logic [COORD_BITS-1:0] end_col, end_row;
	logic [7:0]            end_exp, end_act;

	always_comb begin
		geom_ok   = (frame_width >= COORD_BITS'(2)) && (frame_height != '0);
		check_on  = pattern_en && geom_ok;
		in_rows   = row_q < frame_height;
		at_origin = (col_q == '0) && (row_q == '0);
		at_second = (col_q == COORD_BITS'(1)) && (row_q == '0);
		cmp_exp   = (col_q == '0) ? first_q : expect_q;
		col_inc   = {1'b0, col_q} + (COORD_BITS+1)'(1);

		first_n  = first_q;
		expect_n = expect_q;
		dir_n    = dir_q;
		failed_n = failed_q;
		fcol_n   = fcol_q;
		frow_n   = frow_q;
		fexp_n   = fexp_q;
		fact_n   = fact_q;
		col_n    = col_q;
		row_n    = row_q;

		if (stored && check_on && !failed_q && in_rows) begin
			if (at_origin) begin
				if (!cfic_pkg::one_hot(pix)) begin
					failed_n = 1'b1;
					fcol_n   = '0;
					frow_n   = '0;
					fexp_n   = 8'd0;
					fact_n   = pix;
				end else begin
					first_n = pix;
				end
			end else if (at_second) begin
				if (pix == cfic_pkg::rot_l(first_q)) begin
					dir_n    = 1'b1;
					expect_n = cfic_pkg::rot_l(pix);
				end else if (pix == cfic_pkg::rot_r(first_q)) begin
					dir_n    = 1'b0;
					expect_n = cfic_pkg::rot_r(pix);
				end else begin
					failed_n = 1'b1;
					fcol_n   = COORD_BITS'(1);
					frow_n   = '0;
					fexp_n   = cfic_pkg::rot_l(first_q);
					fact_n   = pix;
				end
			end else if (!cfic_pkg::one_hot(pix) || (pix != cmp_exp)) begin
				failed_n = 1'b1;
				fcol_n   = col_q;
				frow_n   = row_q;
				fexp_n   = cmp_exp;
				fact_n   = pix;
			end else begin
				expect_n = dir_q ? cfic_pkg::rot_l(cmp_exp) : cfic_pkg::rot_r(cmp_exp);
			end
		end

		// advance position; wrap to next row at the row end
		if (stored && in_rows) begin
			if (col_inc >= {1'b0, frame_width}) begin
				col_n = '0;
				row_n = row_q + COORD_BITS'(1);
			end else begin
				col_n = col_inc[COORD_BITS-1:0];
			end
		end

		// short frame: first missing pixel counts as a mismatch with zero
		end_failed = failed_n;
		end_col    = fcol_n;
		end_row    = frow_n;
		end_exp    = fexp_n;
		end_act    = fact_n;
		if (check_on && !failed_n && (row_n < frame_height)) begin
			end_failed = 1'b1;
			end_col    = col_n;
			end_row    = row_n;
			end_act    = 8'd0;
			if (col_n == '0) begin
				end_exp = (row_n == '0) ? 8'd0 : first_n;
			end else if ((row_n == '0) && (col_n == COORD_BITS'(1))) begin
				end_exp = cfic_pkg::rot_l(first_n);
			end else begin
				end_exp = expect_n;
			end
		end

		status.ok          = 1'b1;
		status.rotate_left = 1'b0;
		rec_col = '0;
		rec_row = '0;
		rec_exp = 8'd0;
		rec_act = 8'd0;
		priority if (!pattern_en) begin
			status.ok = 1'b1;
		end else if (!geom_ok) begin
			status.ok = 1'b0;
		end else if (end_failed) begin
			status.ok = 1'b0;
			rec_col   = end_col;
			rec_row   = end_row;
			rec_exp   = end_exp;
			rec_act   = end_act;
		end else begin
			status.ok          = 1'b1;
			status.rotate_left = dir_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			first_q  <= 8'd0;
			expect_q <= 8'd0;
			dir_q    <= 1'b0;
			failed_q <= 1'b0;
			fcol_q   <= '0;
			frow_q   <= '0;
			fexp_q   <= 8'd0;
			fact_q   <= 8'd0;
		end else if (step) begin
			if (last) begin
				col_q    <= '0;
				row_q    <= '0;
				first_q  <= 8'd0;
				expect_q <= 8'd0;
				dir_q    <= 1'b0;
				failed_q <= 1'b0;
				fcol_q   <= '0;
				frow_q   <= '0;
				fexp_q   <= 8'd0;
				fact_q   <= 8'd0;
			end else begin
				col_q    <= col_n;
				row_q    <= row_n;
				first_q  <= first_n;
				expect_q <= expect_n;
				dir_q    <= dir_n;
				failed_q <= failed_n;
				fcol_q   <= fcol_n;
				frow_q   <= frow_n;
				fexp_q   <= fexp_n;
				fact_q   <= fact_n;
			end
		end
	end

endmodule

/* sv/cfic_verdict.sv */
// ----------------------------------------------------------------------------
// cfic_verdict
// Size and CRC baselines, frame verdict and the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cfic_verdict #(
	parameter int COORD_BITS = 12,
	parameter int COUNT_BITS = 24
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    fire,
	input  logic [COUNT_BITS:0]     count,
	input  logic [2*COORD_BITS-1:0] payload,
	input  logic [COUNT_BITS-1:0]   capacity,
	input  logic [31:0]             crc,
	input  cfic_pkg::pat_status_t   status,
	input  logic [COORD_BITS-1:0]   rec_col,
	input  logic [COORD_BITS-1:0]   rec_row,
	input  logic [7:0]              rec_exp,
	input  logic [7:0]              rec_act,
	input  logic                    out_ready,
	output logic                    out_valid,
	output logic                    frame_valid,
	output logic                    size_error,
	output logic                    size_changed,
	output logic                    crc_changed,
	output logic [31:0]             payload_crc,
	output logic [COUNT_BITS:0]     received_bytes,
	output logic                    pattern_ok,
	output logic                    rotate_left,
	output logic [COORD_BITS-1:0]   mismatch_column,
	output logic [COORD_BITS-1:0]   mismatch_row,
	output logic [7:0]              expected_byte,
	output logic [7:0]              actual_byte
);

	localparam int CNT_BITS = COUNT_BITS + 1;
	localparam int PAY_BITS = 2 * COORD_BITS;
	localparam int CMP_BITS = (PAY_BITS > CNT_BITS) ? PAY_BITS : CNT_BITS;

	logic                base_size_known_q, base_crc_known_q;
	logic [CNT_BITS-1:0] base_size_q;
	logic [31:0]         base_crc_q;
	logic                out_valid_q;

	logic                size_bad, size_chg, crc_chg, take_size, out_of_range;
	logic                frame_valid_q, size_error_q, size_changed_q, crc_changed_q;
	logic [31:0]         crc_q;
	logic [CNT_BITS-1:0] count_q;
	logic                pat_ok_q, rot_left_q;
	logic [COORD_BITS-1:0] col_q, row_q;
	logic [7:0]          exp_q, act_q;

	always_comb begin
		out_of_range = (CMP_BITS'(count) < CMP_BITS'(payload)) ||
			(count > CNT_BITS'(capacity));
		size_bad  = 1'b0;
		size_chg  = 1'b0;
		take_size = 1'b0;
		priority if (out_of_range) begin
			size_bad = 1'b1;
		end else if (!base_size_known_q) begin
			take_size = 1'b1;
		end else if (count != base_size_q) begin
			size_bad = 1'b1;
			size_chg = 1'b1;
		end
		crc_chg = base_crc_known_q && (crc != base_crc_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_size_known_q <= 1'b0;
			base_size_q       <= '0;
			base_crc_known_q  <= 1'b0;
			base_crc_q        <= 32'd0;
		end else if (fire) begin
			if (take_size) begin
				base_size_known_q <= 1'b1;
				base_size_q       <= count;
			end
			if (!base_crc_known_q) begin
				base_crc_known_q <= 1'b1;
				base_crc_q       <= crc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload, loaded on the frame's last byte
	always_ff @(posedge clk) begin
		if (fire) begin
			frame_valid_q  <= !size_bad && status.ok && !crc_chg;
			size_error_q   <= size_bad;
			size_changed_q <= size_chg;
			crc_changed_q  <= crc_chg;
			crc_q          <= crc;
			count_q        <= count;
			pat_ok_q       <= status.ok;
			rot_left_q     <= status.rotate_left;
			col_q          <= rec_col;
			row_q          <= rec_row;
			exp_q          <= rec_exp;
			act_q          <= rec_act;
		end
	end

	assign out_valid       = out_valid_q;
	assign frame_valid     = frame_valid_q;
	assign size_error      = size_error_q;
	assign size_changed    = size_changed_q;
	assign crc_changed     = crc_changed_q;
	assign payload_crc     = crc_q;
	assign received_bytes  = count_q;
	assign pattern_ok      = pat_ok_q;
	assign rotate_left     = rot_left_q;
	assign mismatch_column = col_q;
	assign mismatch_row    = row_q;
	assign expected_byte   = exp_q;
	assign actual_byte     = act_q;

	`CFIC_ASSERT_IMP(a_chg_is_err, out_valid_q && size_changed_q, size_error_q, "size change without size error")
	`CFIC_ASSERT_IMP(a_valid_clean, out_valid_q && frame_valid_q, !size_error_q && pat_ok_q && !crc_changed_q, "frame valid with a failed check")
	`CFIC_ASSERT_IMP(a_fail_no_dir, out_valid_q && !pat_ok_q, !rot_left_q, "direction reported on failed pattern")
	`CFIC_ASSERT_NXT(a_base_taken, fire, base_crc_known_q, "crc baseline not taken after a frame")

endmodule

/* sv/camera_frame_integrity_checker.sv */
// ----------------------------------------------------------------------------
// camera_frame_integrity_checker
// Per-frame byte count, CRC-32 and walking-one pattern check, one verdict per
// frame; CRC baseline from the first frame, size from the first in-range one.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------
//  in       | in_valid / in_ready   | pixel_byte, frame_last
//  out      | out_valid / out_ready | frame verdict, CRC, count, mismatch data
//  cfg      | cfg_write             | cfg_index, cfg_data
//
//  One byte per cycle sustained while out is not stalled on a frame_last byte:
//  a byte is held in the input register, where count, CRC and pattern state
//  update in a single pass. The verdict is loaded into the result register at
//  the edge where the frame_last byte leaves the input register; the result
//  register lets the next frame's bytes flow on.
//  A stalled out only holds a frame_last byte in the input register.
//  Reset clears all frame state and both baselines; configuration takes
//  its defaults.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module camera_frame_integrity_checker #(
	parameter int COORD_BITS = 12,
	parameter int COUNT_BITS = 24,
	localparam int DATA_BITS = (COUNT_BITS > COORD_BITS) ? COUNT_BITS : COORD_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [cfic_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [DATA_BITS-1:0]                cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [7:0]                          pixel_byte,
	input  logic                                frame_last,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                frame_valid,
	output logic                                size_error,
	output logic                                size_changed,
	output logic                                crc_changed,
	output logic [31:0]                         payload_crc,
	output logic [COUNT_BITS:0]                 received_bytes,
	output logic                                pattern_ok,
	output logic                                rotate_left,
	output logic [COORD_BITS-1:0]               mismatch_column,
	output logic [COORD_BITS-1:0]               mismatch_row,
	output logic [7:0]                          expected_byte,
	output logic [7:0]                          actual_byte
);

	localparam int CNT_BITS = COUNT_BITS + 1;
	localparam int PAY_BITS = 2 * COORD_BITS;
	localparam int CMP_BITS = (PAY_BITS > CNT_BITS) ? PAY_BITS : CNT_BITS;

	logic [COORD_BITS-1:0] width, height;
	logic [COUNT_BITS-1:0] capacity;
	logic                  pattern_en;
	logic [PAY_BITS-1:0]   payload;

	logic                  valid_s1;
	logic [7:0]            byte_s1;
	logic                  last_s1;

	logic [CNT_BITS-1:0]   count_q, count_n;
	logic [31:0]           crc_q, crc_n;
	logic                  step, stored, fire;

	cfic_pkg::pat_status_t pat_status;
	logic [COORD_BITS-1:0] rec_col, rec_row;
	logic [7:0]            rec_exp, rec_act;

	cfic_regs #(
		.COORD_BITS (COORD_BITS),
		.COUNT_BITS (COUNT_BITS),
		.DATA_BITS  (DATA_BITS)
	) u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.frame_width  (width),
		.frame_height (height),
		.capacity     (capacity),
		.pattern_en   (pattern_en),
		.payload      (payload)
	);

	// a last byte waits until the result register is free
	assign step     = valid_s1 && (!last_s1 || !out_valid || out_ready);
	assign fire     = step && last_s1;
	assign in_ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= pixel_byte;
			last_s1 <= frame_last;
		end
	end

	always_comb begin
		stored  = (CMP_BITS'(count_q) < CMP_BITS'(payload)) &&
			(count_q < CNT_BITS'(capacity));
		crc_n   = stored ? cfic_pkg::crc_byte(crc_q, byte_s1) : crc_q;
		// saturate one past capacity
		count_n = (count_q <= CNT_BITS'(capacity)) ? count_q + CNT_BITS'(1) : count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			crc_q   <= cfic_pkg::CRC_PRESET;
		end else if (step) begin
			if (last_s1) begin
				count_q <= '0;
				crc_q   <= cfic_pkg::CRC_PRESET;
			end else begin
				count_q <= count_n;
				crc_q   <= crc_n;
			end
		end
	end

	cfic_pattern #(
		.COORD_BITS (COORD_BITS)
	) u_pattern (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.stored       (stored),
		.last         (last_s1),
		.pix          (byte_s1),
		.frame_width  (width),
		.frame_height (height),
		.pattern_en   (pattern_en),
		.status       (pat_status),
		.rec_col      (rec_col),
		.rec_row      (rec_row),
		.rec_exp      (rec_exp),
		.rec_act      (rec_act)
	);

	cfic_verdict #(
		.COORD_BITS (COORD_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_verdict (
		.clk             (clk),
		.arst_n          (arst_n),
		.fire            (fire),
		.count           (count_n),
		.payload         (payload),
		.capacity        (capacity),
		.crc             (~crc_n),
		.status          (pat_status),
		.rec_col         (rec_col),
		.rec_row         (rec_row),
		.rec_exp         (rec_exp),
		.rec_act         (rec_act),
		.out_ready       (out_ready),
		.out_valid       (out_valid),
		.frame_valid     (frame_valid),
		.size_error      (size_error),
		.size_changed    (size_changed),
		.crc_changed     (crc_changed),
		.payload_crc     (payload_crc),
		.received_bytes  (received_bytes),
		.pattern_ok      (pattern_ok),
		.rotate_left     (rotate_left),
		.mismatch_column (mismatch_column),
		.mismatch_row    (mismatch_row),
		.expected_byte   (expected_byte),
		.actual_byte     (actual_byte)
	);

	`CFIC_ASSERT_NXT(a_frame_restart, fire, (count_q == '0) && (crc_q == cfic_pkg::CRC_PRESET), "frame state not cleared after last byte")
	`CFIC_ASSERT_NXT(a_result_after_last, fire, out_valid, "no result after last byte")

endmodule
